[rtl/rpp_pkg.sv]
// Package for the RGB pixel pack writer: widths, register codes,
// configuration struct and pipeline enable struct. No dependencies.
`default_nettype none

package rpp_pkg;

    // Coordinate handling
    localparam int COORD_BITS      = 16;
    localparam int MAX_PIXEL_BYTES = 4;
    localparam int COORD_W         = 16;
    localparam int COORD_KEEP      = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] COORD_MASK =
        COORD_W'((33'd1 << COORD_KEEP) - 33'd1);

    // Field widths
    localparam int CHAN_W   = 8;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 3;
    localparam int PITCH_W  = 18;
    localparam int LAYOUT_W = 9;
    localparam int SIZE_W   = 4;
    localparam int POS_W    = 5;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 18;

    // Rounding bias and full-scale channel value
    localparam logic [14:0] ROUND_BIAS = 15'd127;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;

    // Pass-through threshold for channel size
    localparam logic [SIZE_W-1:0] SIZE_PASS = 4'd8;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_ROW_PITCH     = 3'd2,
        REG_PIXEL_BYTES   = 3'd3,
        REG_RED_LAYOUT    = 3'd4,
        REG_GREEN_LAYOUT  = 3'd5,
        REG_BLUE_LAYOUT   = 3'd6,
        REG_PAD_LAYOUT    = 3'd7
    } cfg_reg_t;

    // Register file contents
    typedef struct packed {
        logic [COORD_W-1:0]  screen_width;
        logic [COORD_W-1:0]  screen_height;
        logic [PITCH_W-1:0]  row_pitch;
        logic [COUNT_W-1:0]  pixel_bytes;
        logic [LAYOUT_W-1:0] red_layout;
        logic [LAYOUT_W-1:0] green_layout;
        logic [LAYOUT_W-1:0] blue_layout;
        logic [LAYOUT_W-1:0] pad_layout;
    } cfg_t;

    // Stage load enables for the datapath slices
    typedef struct packed {
        logic s1;
        logic s2;
    } pipe_en_t;

endpackage

`default_nettype wire

[rtl/rpp_if.sv]
// Stream interfaces for the pixel pack writer: input pixel beats and
// output write beats. Depends on rpp_pkg.
`default_nettype none

interface rpp_pix_if;
    logic                             valid;
    logic                             ready;
    logic [rpp_pkg::COORD_W-1:0]      pos_x;
    logic [rpp_pkg::COORD_W-1:0]      pos_y;
    logic [rpp_pkg::CHAN_W-1:0]       red_in;
    logic [rpp_pkg::CHAN_W-1:0]       green_in;
    logic [rpp_pkg::CHAN_W-1:0]       blue_in;

    modport source (output valid, pos_x, pos_y, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, pos_x, pos_y, red_in, green_in, blue_in, output ready);
endinterface

interface rpp_wr_if;
    logic                             valid;
    logic                             ready;
    logic                             write_valid;
    logic [rpp_pkg::WORD_W-1:0]       byte_offset;
    logic [rpp_pkg::WORD_W-1:0]       pixel_word;
    logic [rpp_pkg::COUNT_W-1:0]      byte_count;

    modport source (output valid, write_valid, byte_offset, pixel_word, byte_count,
                    input ready);
    modport sink   (input valid, write_valid, byte_offset, pixel_word, byte_count,
                    output ready);
endinterface

`default_nettype wire

[rtl/rpp_cfg.sv]
// Configuration register file for the pixel pack writer.
// Depends on rpp_pkg.
`default_nettype none

module rpp_cfg (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rpp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output rpp_pkg::cfg_t                           cfg
);

    rpp_pkg::cfg_t cfg_reg;
    rpp_pkg::cfg_t cfg_next;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (rpp_pkg::cfg_reg_t'(cfg_index))
                rpp_pkg::REG_SCREEN_WIDTH:
                    cfg_next.screen_width  = cfg_data[rpp_pkg::COORD_W-1:0];
                rpp_pkg::REG_SCREEN_HEIGHT:
                    cfg_next.screen_height = cfg_data[rpp_pkg::COORD_W-1:0];
                rpp_pkg::REG_ROW_PITCH:
                    cfg_next.row_pitch     = cfg_data[rpp_pkg::PITCH_W-1:0];
                rpp_pkg::REG_PIXEL_BYTES:
                    cfg_next.pixel_bytes   = cfg_data[rpp_pkg::COUNT_W-1:0];
                rpp_pkg::REG_RED_LAYOUT:
                    cfg_next.red_layout    = cfg_data[rpp_pkg::LAYOUT_W-1:0];
                rpp_pkg::REG_GREEN_LAYOUT:
                    cfg_next.green_layout  = cfg_data[rpp_pkg::LAYOUT_W-1:0];
                rpp_pkg::REG_BLUE_LAYOUT:
                    cfg_next.blue_layout   = cfg_data[rpp_pkg::LAYOUT_W-1:0];
                rpp_pkg::REG_PAD_LAYOUT:
                    cfg_next.pad_layout    = cfg_data[rpp_pkg::LAYOUT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Register file with reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= 16'd640;
            cfg_reg.screen_height <= 16'd480;
            cfg_reg.row_pitch     <= 18'd2560;
            cfg_reg.pixel_bytes   <= 3'd0;
            cfg_reg.red_layout    <= 9'd0;
            cfg_reg.green_layout  <= 9'd0;
            cfg_reg.blue_layout   <= 9'd0;
            cfg_reg.pad_layout    <= 9'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/rpp_chan.sv]
// One color channel slice: rescale with rounding over two stages, then
// shift into place. Depends on rpp_pkg.
`default_nettype none

module rpp_chan (
    input  wire logic                               clk,
    input  wire rpp_pkg::pipe_en_t                  en,
    input  wire logic [rpp_pkg::CHAN_W-1:0]         value,
    input  wire logic [rpp_pkg::LAYOUT_W-1:0]       layout,
    output logic [rpp_pkg::WORD_W-1:0]              word
);

    logic [rpp_pkg::SIZE_W-1:0] size;
    logic [rpp_pkg::POS_W-1:0]  pos;
    logic [6:0]                 top;
    logic [14:0]                prod_reg;
    logic [14:0]                prod_next;
    logic [rpp_pkg::CHAN_W-1:0] value_reg;
    logic [15:0]                div_sum;
    logic [rpp_pkg::CHAN_W-1:0] quot;
    logic [rpp_pkg::CHAN_W-1:0] scaled;
    logic [rpp_pkg::WORD_W-1:0] word_reg;
    logic [rpp_pkg::WORD_W-1:0] word_next;

    // User must keep layout fields fixed while items are in flight, unchecked
    assign size = layout[rpp_pkg::SIZE_W-1:0];
    assign pos  = layout[rpp_pkg::LAYOUT_W-1:rpp_pkg::SIZE_W];

    // Stage 1: v * (2^s - 1) + 127, valid for sizes 1..7
    assign top       = 7'((8'd1 << size[2:0]) - 8'd1);
    assign prod_next = 15'(value) * 15'(top) + rpp_pkg::ROUND_BIAS;

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            prod_reg  <= prod_next;
            value_reg <= value;
        end
    end

    // Stage 2: divide by 255 as (t + 1 + (t >> 8)) >> 8, exact below 65535
    assign div_sum = 16'(prod_reg) + 16'd1 + 16'(prod_reg >> 8);
    assign quot    = div_sum[15:8];

    always_comb
    begin
        if (size == '0)
            scaled = '0;
        else if (size >= rpp_pkg::SIZE_PASS)
            scaled = value_reg;
        else
            scaled = quot;
    end

    // Shift into place; bits above the word drop off
    assign word_next = rpp_pkg::WORD_W'(scaled) << pos;

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

[rtl/rpp_offset.sv]
// Byte offset slice: y * pitch and x * bytes per pixel in stage 1,
// their sum modulo 2^32 in stage 2. Depends on rpp_pkg.
`default_nettype none

module rpp_offset (
    input  wire logic                               clk,
    input  wire rpp_pkg::pipe_en_t                  en,
    input  wire logic [rpp_pkg::COORD_W-1:0]        x,
    input  wire logic [rpp_pkg::COORD_W-1:0]        y,
    input  wire logic [rpp_pkg::PITCH_W-1:0]        pitch,
    input  wire logic [rpp_pkg::COUNT_W-1:0]        bpp,
    output logic [rpp_pkg::WORD_W-1:0]              offset
);

    localparam int ROW_PROD_W = rpp_pkg::COORD_W + rpp_pkg::PITCH_W;
    localparam int COL_PROD_W = rpp_pkg::COORD_W + rpp_pkg::COUNT_W;

    logic [ROW_PROD_W-1:0]      row_prod;
    logic [COL_PROD_W-1:0]      col_prod;
    logic [rpp_pkg::WORD_W-1:0] row_reg;
    logic [COL_PROD_W-1:0]      col_reg;
    logic [rpp_pkg::WORD_W-1:0] offset_reg;
    logic [rpp_pkg::WORD_W-1:0] offset_next;

    // Stage 1: the two products
    assign row_prod = ROW_PROD_W'(y) * ROW_PROD_W'(pitch);
    assign col_prod = COL_PROD_W'(x) * COL_PROD_W'(bpp);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            row_reg <= row_prod[rpp_pkg::WORD_W-1:0];
            col_reg <= col_prod;
        end
    end

    // Stage 2: wrap-around sum
    assign offset_next = row_reg + rpp_pkg::WORD_W'(col_reg);

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            offset_reg <= offset_next;
        end
    end

    assign offset = offset_reg;

endmodule

`default_nettype wire

[rtl/rgb_pixel_pack_writer.sv]
// Top level of the RGB pixel pack writer: handshake control, clip check,
// final merge and output register. Depends on rpp_pkg, rpp_if, rpp_cfg,
// rpp_chan and rpp_offset.
`default_nettype none

// Converts a stream of 8-bit RGB pixels with screen coordinates into packed
// framebuffer writes: one result beat per pixel beat, in order. The block
// takes one pixel per clock while the output is not stalled; an accepted
// pixel passes through three registered stages to the output: stage 1 forms
// the channel products and the offset products, stage 2 divides by 255,
// shifts the channels and adds the offset, stage 3 merges the word and is the
// output register. Every stage holds its beat while the output is stalled, so
// input ready falls only when all three stages are full. Clipped or disabled
// pixels still give a beat, with write_valid low and all fields zero.
// byte_offset excludes the framebuffer base. Registers are written through
// cfg_we/cfg_index/cfg_data and must only change while no pixel is in flight.
module rgb_pixel_pack_writer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rpp_pkg::CFG_DATA_W-1:0]     cfg_data,
    rpp_pix_if.sink                                 pix,
    rpp_wr_if.source                                wr
);

    rpp_pkg::cfg_t              cfg;
    rpp_pkg::pipe_en_t          en;

    logic                       v1_reg;
    logic                       v2_reg;
    logic                       v3_reg;
    logic                       rdy1;
    logic                       rdy2;
    logic                       rdy3;

    logic [rpp_pkg::COORD_W-1:0] x;
    logic [rpp_pkg::COORD_W-1:0] y;
    logic [rpp_pkg::COUNT_W-1:0] bpp_sat;
    logic                        keep_next;
    logic                        keep1_reg;
    logic                        keep2_reg;
    logic [rpp_pkg::COUNT_W-1:0] bpp1_reg;
    logic [rpp_pkg::COUNT_W-1:0] bpp2_reg;

    logic [rpp_pkg::WORD_W-1:0]  red_word;
    logic [rpp_pkg::WORD_W-1:0]  green_word;
    logic [rpp_pkg::WORD_W-1:0]  blue_word;
    logic [rpp_pkg::WORD_W-1:0]  pad_word;
    logic [rpp_pkg::WORD_W-1:0]  offset;

    logic                        wv_reg;
    logic [rpp_pkg::WORD_W-1:0]  off_reg;
    logic [rpp_pkg::WORD_W-1:0]  word_reg;
    logic [rpp_pkg::COUNT_W-1:0] cnt_reg;

    // Registers
    rpp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stage handshake: a stage loads when it is empty or its beat moves on
    assign rdy3  = !v3_reg || wr.ready;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign en.s1 = rdy1;
    assign en.s2 = rdy2;
    assign pix.ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= pix.valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    // Coordinate mask, bytes per pixel saturation and clip check
    assign x = pix.pos_x & rpp_pkg::COORD_MASK;
    assign y = pix.pos_y & rpp_pkg::COORD_MASK;
    assign bpp_sat = (cfg.pixel_bytes > rpp_pkg::COUNT_W'(rpp_pkg::MAX_PIXEL_BYTES))
                   ? rpp_pkg::COUNT_W'(rpp_pkg::MAX_PIXEL_BYTES) : cfg.pixel_bytes;
    assign keep_next = (bpp_sat >= 3'd2) && (x < cfg.screen_width)
                    && (y < cfg.screen_height);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            keep1_reg <= keep_next;
            bpp1_reg  <= bpp_sat;
        end
        if (en.s2)
        begin
            keep2_reg <= keep1_reg;
            bpp2_reg  <= bpp1_reg;
        end
    end

    // Channel slices; the reserved channel rescales full scale to its maximum
    rpp_chan u_red (
        .clk    (clk),
        .en     (en),
        .value  (pix.red_in),
        .layout (cfg.red_layout),
        .word   (red_word)
    );

    rpp_chan u_green (
        .clk    (clk),
        .en     (en),
        .value  (pix.green_in),
        .layout (cfg.green_layout),
        .word   (green_word)
    );

    rpp_chan u_blue (
        .clk    (clk),
        .en     (en),
        .value  (pix.blue_in),
        .layout (cfg.blue_layout),
        .word   (blue_word)
    );

    rpp_chan u_pad (
        .clk    (clk),
        .en     (en),
        .value  (rpp_pkg::CHAN_FULL),
        .layout (cfg.pad_layout),
        .word   (pad_word)
    );

    // Byte offset slice
    rpp_offset u_offset (
        .clk    (clk),
        .en     (en),
        .x      (x),
        .y      (y),
        .pitch  (cfg.row_pitch),
        .bpp    (bpp_sat),
        .offset (offset)
    );

    // Stage 3: merge and zero clipped beats into the output register
    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            wv_reg   <= keep2_reg;
            off_reg  <= keep2_reg ? offset : '0;
            word_reg <= keep2_reg ? (red_word | green_word | blue_word | pad_word) : '0;
            cnt_reg  <= keep2_reg ? bpp2_reg : '0;
        end
    end

    assign wr.valid       = v3_reg;
    assign wr.write_valid = wv_reg;
    assign wr.byte_offset = off_reg;
    assign wr.pixel_word  = word_reg;
    assign wr.byte_count  = cnt_reg;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for rgb_pixel_pack_writer: a queue-fed pixel driver,
// a write-beat monitor and a predictor of the packed word and byte offset.
// Depends on rpp_pkg, rpp_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
    import rpp_pkg::*;

    localparam int NUM_REGS          = 8;
    localparam int RESET_CYCLES      = 9;
    localparam int RAND_SETTINGS     = 12;
    localparam int PIXELS_PER_SET    = 120;
    localparam int MAX_REPORTS       = 10;
    localparam int STALL_LIMIT       = 2000;
    localparam int TAIL_CYCLES       = 8;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
    } pixel_t;

    typedef struct packed {
        logic               write_valid;
        logic [WORD_W-1:0]  byte_offset;
        logic [WORD_W-1:0]  pixel_word;
        logic [COUNT_W-1:0] byte_count;
    } fb_write_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rpp_pix_if pix ();
    rpp_wr_if  wr ();

    rgb_pixel_pack_writer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .wr        (wr)
    );

    // Shadow of the register file, pixels waiting to go, predicted writes
    cfg_t        fb_cfg;
    pixel_t      pixel_queue[$];
    fb_write_t   pending_writes[$];

    int send_idle_pct;
    int recv_idle_pct;
    int unsigned pixels_sent;
    int unsigned writes_seen;
    int unsigned writes_stored;
    int unsigned settings_used;
    int unsigned fail_count;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Rescale an 8-bit level to a channel of the given size, with rounding
    function automatic logic [CHAN_W-1:0] rescale_level(logic [CHAN_W-1:0] level,
                                                        logic [SIZE_W-1:0] size);
        int unsigned top;
        if (size == 0)
            return '0;
        if (size >= SIZE_PASS)
            return level;
        top = (1 << size) - 1;
        return CHAN_W'((level * top + int'(ROUND_BIAS)) / int'(CHAN_FULL));
    endfunction

    // Scaled channel shifted to its position; bits above 31 fall off
    function automatic logic [WORD_W-1:0] place_channel(logic [CHAN_W-1:0] level,
                                                        logic [LAYOUT_W-1:0] layout);
        logic [63:0] wide;
        wide = 64'(rescale_level(level, layout[SIZE_W-1:0])) << layout[LAYOUT_W-1:SIZE_W];
        return wide[WORD_W-1:0];
    endfunction

    function automatic fb_write_t pack_pixel(pixel_t p);
        fb_write_t   res;
        int unsigned bpp;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [63:0] ofs;
        res = '0;
        cx  = p.x & COORD_MASK;
        cy  = p.y & COORD_MASK;
        bpp = (fb_cfg.pixel_bytes > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : fb_cfg.pixel_bytes;
        // disabled output or off-screen pixel: all-zero beat
        if (bpp < 2 || cx >= fb_cfg.screen_width || cy >= fb_cfg.screen_height)
            return res;
        res.pixel_word = place_channel(p.r, fb_cfg.red_layout)
                       | place_channel(p.g, fb_cfg.green_layout)
                       | place_channel(p.b, fb_cfg.blue_layout);
        if (fb_cfg.pad_layout[SIZE_W-1:0] != 0)
            res.pixel_word |= place_channel(CHAN_FULL, fb_cfg.pad_layout);
        ofs = 64'(cy) * 64'(fb_cfg.row_pitch) + 64'(cx) * 64'(bpp);
        res.byte_offset = ofs[WORD_W-1:0];
        res.byte_count  = COUNT_W'(bpp);
        res.write_valid = 1'b1;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: predicts on each accepted beat, then offers the next one
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : pixel_driver
        pixel_t nxt;
        if (!rst_n) begin
            pix.valid    <= 1'b0;
            pix.pos_x    <= '0;
            pix.pos_y    <= '0;
            pix.red_in   <= '0;
            pix.green_in <= '0;
            pix.blue_in  <= '0;
        end
        else begin
            if (pix.valid && pix.ready) begin
                pending_writes.push_back(pack_pixel('{pix.pos_x, pix.pos_y, pix.red_in,
                                                      pix.green_in, pix.blue_in}));
                pixels_sent++;
            end
            if (!pix.valid || pix.ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pixel_queue.pop_front();
                    pix.valid    <= 1'b1;
                    pix.pos_x    <= nxt.x;
                    pix.pos_y    <= nxt.y;
                    pix.red_in   <= nxt.r;
                    pix.green_in <= nxt.g;
                    pix.blue_in  <= nxt.b;
                end
                else begin
                    pix.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Write monitor: checks each write beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : write_monitor
        fb_write_t got;
        fb_write_t want;
        if (!rst_n) begin
            wr.ready <= 1'b0;
        end
        else begin
            if (wr.valid && wr.ready) begin
                got = '{wr.write_valid, wr.byte_offset, wr.pixel_word, wr.byte_count};
                writes_seen++;
                if (got.write_valid === 1'b1)
                    writes_stored++;
                if (pending_writes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected write beat valid=%0b ofs=%h word=%h cnt=%0d",
                                 $realtime, got.write_valid, got.byte_offset,
                                 got.pixel_word, got.byte_count);
                end
                else begin
                    want = pending_writes.pop_front();
                    if (got.write_valid !== want.write_valid
                        || got.byte_offset !== want.byte_offset
                        || got.pixel_word !== want.pixel_word
                        || got.byte_count !== want.byte_count) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display({"%0t: write beat %0d mismatch: exp valid=%0b ofs=%h ",
                                      "word=%h cnt=%0d / got valid=%0b ofs=%h word=%h cnt=%0d"},
                                     $realtime, writes_seen, want.write_valid,
                                     want.byte_offset, want.pixel_word, want.byte_count,
                                     got.write_valid, got.byte_offset, got.pixel_word,
                                     got.byte_count);
                    end
                end
            end
            wr.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no beat on either channel
    // ------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((pix.valid && pix.ready) || (wr.valid && wr.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("rgb_pixel_pack_writer regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One register write; shadow keeps only the register's own bits
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_SCREEN_WIDTH:  fb_cfg.screen_width  = data[COORD_W-1:0];
            REG_SCREEN_HEIGHT: fb_cfg.screen_height = data[COORD_W-1:0];
            REG_ROW_PITCH:     fb_cfg.row_pitch     = data[PITCH_W-1:0];
            REG_PIXEL_BYTES:   fb_cfg.pixel_bytes   = data[COUNT_W-1:0];
            REG_RED_LAYOUT:    fb_cfg.red_layout    = data[LAYOUT_W-1:0];
            REG_GREEN_LAYOUT:  fb_cfg.green_layout  = data[LAYOUT_W-1:0];
            REG_BLUE_LAYOUT:   fb_cfg.blue_layout   = data[LAYOUT_W-1:0];
            REG_PAD_LAYOUT:    fb_cfg.pad_layout    = data[LAYOUT_W-1:0];
            default: ;
        endcase
    endtask

    // Write all registers; random junk rides above each register's width
    task automatic load_settings(cfg_t s);
        logic [CFG_DATA_W-1:0] data;
        for (int i = 0; i < NUM_REGS; i++) begin
            data = CFG_DATA_W'($urandom);
            case (cfg_reg_t'(i))
                REG_SCREEN_WIDTH:  data[COORD_W-1:0]  = s.screen_width;
                REG_SCREEN_HEIGHT: data[COORD_W-1:0]  = s.screen_height;
                REG_ROW_PITCH:     data[PITCH_W-1:0]  = s.row_pitch;
                REG_PIXEL_BYTES:   data[COUNT_W-1:0]  = s.pixel_bytes;
                REG_RED_LAYOUT:    data[LAYOUT_W-1:0] = s.red_layout;
                REG_GREEN_LAYOUT:  data[LAYOUT_W-1:0] = s.green_layout;
                REG_BLUE_LAYOUT:   data[LAYOUT_W-1:0] = s.blue_layout;
                REG_PAD_LAYOUT:    data[LAYOUT_W-1:0] = s.pad_layout;
                default: ;
            endcase
            write_reg(cfg_reg_t'(i), data);
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
        @(negedge clk);
    endtask

    // Called after a falling edge, away from the driver's pops
    task automatic queue_pixel(int unsigned x, int unsigned y,
                               int unsigned r, int unsigned g, int unsigned b);
        pixel_queue.push_back('{COORD_W'(x), COORD_W'(y), CHAN_W'(r), CHAN_W'(g),
                                CHAN_W'(b)});
    endtask

    // Wait until every queued pixel has gone and every write beat is back
    task automatic drain();
        do
            @(negedge clk);
        while (pixel_queue.size() != 0 || pix.valid || pending_writes.size() != 0);
    endtask

    function automatic logic [COORD_W-1:0] rand_extent();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return COORD_W'($urandom_range(1024, 1));
        if (pick < 90)
            return COORD_W'($urandom);
        if (pick < 95)
            return '1;
        return '0;
    endfunction

    function automatic logic [LAYOUT_W-1:0] rand_layout();
        if ($urandom_range(99) < 60)
            return LAYOUT_W'($urandom);
        return {POS_W'($urandom_range(24)), SIZE_W'($urandom_range(8))};
    endfunction

    function automatic cfg_t rand_setting(int k);
        cfg_t s;
        if (k == 2)
            return '{'1, '1, '1, '1, '1, '1, '1, '1};
        if (k == 7)
            return '{16'd1, 16'd1, 18'd0, 3'd2, 9'd0, 9'd0, 9'd0, 9'd0};
        s.screen_width  = rand_extent();
        s.screen_height = rand_extent();
        if ($urandom_range(1))
            s.row_pitch = PITCH_W'($urandom);
        else
            s.row_pitch = PITCH_W'(s.screen_width * $urandom_range(4));
        if ($urandom_range(99) < 80)
            s.pixel_bytes = COUNT_W'($urandom_range(4, 2));
        else
            s.pixel_bytes = COUNT_W'($urandom_range(7));
        s.red_layout   = rand_layout();
        s.green_layout = rand_layout();
        s.blue_layout  = rand_layout();
        s.pad_layout   = ($urandom_range(1)) ? rand_layout() : '0;
        return s;
    endfunction

    // Coordinate mostly on screen, some at the clip edge, some anywhere
    function automatic logic [COORD_W-1:0] rand_coord(logic [COORD_W-1:0] extent);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 75 && extent != 0)
            return COORD_W'($urandom_range(extent - 1));
        if (pick < 87)
            return COORD_W'(extent + $urandom_range(2) - 1);
        return COORD_W'($urandom);
    endfunction

    function automatic logic [CHAN_W-1:0] rand_level();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 10)
            return '1;
        return CHAN_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        cfg_t s;
        pix.valid     = 1'b0;
        pix.pos_x     = '0;
        pix.pos_y     = '0;
        pix.red_in    = '0;
        pix.green_in  = '0;
        pix.blue_in   = '0;
        wr.ready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SCREEN_WIDTH;
        cfg_data      = '0;
        rst_n         = 1'b0;
        fb_cfg        = '{16'd640, 16'd480, 18'd2560, 3'd0, 9'd0, 9'd0, 9'd0, 9'd0};
        send_idle_pct = 7;
        recv_idle_pct = 63;
        pixels_sent   = 0;
        writes_seen   = 0;
        writes_stored = 0;
        settings_used = 1;
        fail_count    = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values: output disabled
        queue_pixel(0, 0, 0, 0, 0);
        queue_pixel(10, 10, 255, 255, 255);
        drain();

        // RGB565, 640x480: corners, clip on each axis, full-range coordinates
        load_settings('{16'd640, 16'd480, 18'd1280, 3'd2, 9'h0B5, 9'h056, 9'h005, 9'h000});
        queue_pixel(0, 0, 0, 0, 0);
        queue_pixel(639, 479, 255, 255, 255);
        queue_pixel(640, 0, 255, 0, 0);
        queue_pixel(0, 480, 0, 255, 0);
        queue_pixel(65535, 65535, 0, 0, 255);
        queue_pixel(100, 50, 128, 64, 32);
        drain();

        // 32-bit with full pad, largest screen and pitch: offset wraps
        load_settings('{16'hFFFF, 16'hFFFF, 18'h3FFFF, 3'd4, 9'h108, 9'h088, 9'h008, 9'h188});
        queue_pixel(65534, 65534, 8'h12, 8'h34, 8'h56);
        queue_pixel(0, 0, 255, 0, 128);
        queue_pixel(65535, 0, 1, 2, 3);
        drain();

        // Oversized byte count saturates; channels pushed past bit 31
        load_settings('{16'd100, 16'd100, 18'd3, 3'd7, 9'h1FF, 9'h1F1, 9'h0F3, 9'h1EF});
        queue_pixel(99, 99, 255, 255, 255);
        queue_pixel(0, 0, 1, 127, 128);
        queue_pixel(50, 1, 128, 128, 0);
        drain();

        // One byte per pixel: disabled
        load_settings('{16'd640, 16'd480, 18'd640, 3'd1, 9'h0B5, 9'h056, 9'h005, 9'h000});
        queue_pixel(1, 1, 200, 100, 50);
        drain();

        // Zero screen size clips everything
        load_settings('{16'd0, 16'd0, 18'd30, 3'd3, 9'h053, 9'h023, 9'h002, 9'h000});
        queue_pixel(0, 0, 255, 255, 255);
        queue_pixel(3, 7, 9, 9, 9);
        drain();

        // Single-pixel screen, zero pitch, RGB332
        load_settings('{16'd1, 16'd1, 18'd0, 3'd3, 9'h053, 9'h023, 9'h002, 9'h000});
        queue_pixel(0, 0, 200, 100, 50);
        queue_pixel(1, 0, 200, 100, 50);
        queue_pixel(0, 1, 200, 100, 50);
        drain();

        // Random settings, each followed by a burst of random pixels
        for (int k = 0; k < RAND_SETTINGS; k++) begin
            if (k < RAND_SETTINGS / 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 63;
            end
            else if (k < 2 * RAND_SETTINGS / 3) begin
                send_idle_pct = 63;
                recv_idle_pct = 7;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            s = rand_setting(k);
            load_settings(s);
            for (int n = 0; n < PIXELS_PER_SET; n++)
                pixel_queue.push_back('{rand_coord(fb_cfg.screen_width),
                                        rand_coord(fb_cfg.screen_height),
                                        rand_level(), rand_level(), rand_level()});
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        fail_count += pending_writes.size();

        $display("Summary: %0d pixel beats over %0d register settings, %0d write beats checked",
                 pixels_sent, settings_used, writes_seen);
        $display("Summary: %0d beats with write_valid set, %0d failures",
                 writes_stored, fail_count);
        if (fail_count == 0)
            $display("rgb_pixel_pack_writer regression: pass");
        else
            $display("rgb_pixel_pack_writer regression: fail");
        $finish;
    end

endmodule
